/* src/fps_pkg.sv */
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants of the feedback priority scheduler.
// ----------------------------------------------------------------------------
package fps_pkg;

   localparam int TASKS   = 16;
   localparam int LEVELS  = 64;
   localparam int ID_W    = 4;
   localparam int LVL_W   = 6;
   localparam int SLICE_W = 10;
   localparam int KIND_W  = 2;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 24;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_READY   = 2'd1,
      KIND_RESCHED = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_RUN   = 2'd0,
      STATUS_SLEEP = 2'd1,
      STATUS_WAIT  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_POP    = 2'd2
   } cell_op_type;

   // one queue entry
   typedef struct packed {
      logic [ID_W-1:0]  task_id;
      logic [LVL_W-1:0] level;
   } entry_type;

   // command broadcast to every cell of the queue
   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
   } cmd_type;

   // dispatch table row, quantum in the low bits
   typedef struct packed {
      logic [LVL_W-1:0]   sleep_level;
      logic [LVL_W-1:0]   expired_level;
      logic [SLICE_W-1:0] quantum;
   } row_type;

   // request tdata layout without the zero fill, task_id lowest
   typedef struct packed {
      logic               defer_active;
      logic [1:0]         current_status;
      logic [LVL_W-1:0]   row_sleep_level;
      logic [LVL_W-1:0]   row_expired_level;
      logic [SLICE_W-1:0] row_quantum;
      logic [LVL_W-1:0]   level;
      logic [ID_W-1:0]    task_id;
   } item_type;

   // response tdata layout, running_task lowest
   typedef struct packed {
      err_type            error;
      logic               attempt_deferred;
      logic               switched;
      logic [SLICE_W-1:0] slice_ticks;
      logic [LVL_W-1:0]   running_level;
      logic [ID_W-1:0]    running_task;
   } result_type;

endpackage

/* src/fps_ram.sv */
// ----------------------------------------------------------------------------
// fps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fps_cell.sv */
// ----------------------------------------------------------------------------
// fps_cell
// One slot of the sorted ready queue; shifts toward its neighbors.
// ----------------------------------------------------------------------------
module fps_cell (
   input  logic                clock,
   input  fps_pkg::cmd_type    cmd,
   input  logic                occupied,
   input  logic                prev_after,
   input  fps_pkg::entry_type  prev_entry,
   input  fps_pkg::entry_type  next_entry,
   output fps_pkg::entry_type  entry,
   output logic                after
);

   fps_pkg::entry_type entry_ff;
   fps_pkg::entry_type entry_in;

   // new entry goes behind this slot
   assign after = occupied && (entry_ff.level >= cmd.entry.level);

   always_comb begin
      unique case (cmd.op)
         fps_pkg::CELL_INSERT: begin
            if (after) begin
               entry_in = entry_ff;
            end else if (prev_after) begin
               entry_in = cmd.entry;
            end else begin
               entry_in = prev_entry;
            end
         end
         fps_pkg::CELL_POP: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* src/feedback_priority_scheduler_core.sv */
// ----------------------------------------------------------------------------
// feedback_priority_scheduler_core
// Priority ready queue in a row of cells plus a dispatch table in RAM.
//
//   channel | dir | beat fields
//   req_    | in  | tuser: kind; tdata: task_id .. defer_active
//   rsp_    | out | tdata: running_task .. error
//
// load, ready, deferred and unknown beats: ST_DECODE, then ST_DONE raises
//   rsp_tvalid once the previous result is taken
// reschedule: ST_DECODE, a table read wait, ST_REQUEUE and ST_DEQUEUE as needed,
//   the quantum read and ST_DONE; the delay to rsp_tvalid is set by the table's one
//   registered read port, used up to twice per beat, and by a requeue followed by a dequeue
// one beat at a time; req_tready is high while idle, also while a result waits
// synchronous reset clears queue count and running task; no clearing pass
// ----------------------------------------------------------------------------
module feedback_priority_scheduler_core #(
   parameter int TASKS  = fps_pkg::TASKS,
   parameter int LEVELS = fps_pkg::LEVELS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // task_id, level, row_quantum, row_expired_level, row_sleep_level,
   // current_status, defer_active, zero fill
   input  logic [fps_pkg::REQ_W-1:0]   req_tdata,
   // kind
   input  logic [fps_pkg::KIND_W-1:0]  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // running_task, running_level, slice_ticks, switched, attempt_deferred, error
   output logic [fps_pkg::RSP_W-1:0]   rsp_tdata
);

   localparam int CNT_W = $clog2(TASKS + 1);
   localparam int LA_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ROW_W = $bits(fps_pkg::row_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EXP_WAIT,
      ST_SLP_WAIT,
      ST_REQUEUE,
      ST_DEQUEUE,
      ST_QNT_RD,
      ST_QNT_WAIT,
      ST_DONE
   } state_type;

   state_type                     state_ff;
   fps_pkg::item_type             item_ff;
   logic [fps_pkg::KIND_W-1:0]    kind_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [fps_pkg::ID_W-1:0]      cur_task_ff;
   logic [fps_pkg::LVL_W-1:0]     cur_level_ff;
   logic [fps_pkg::SLICE_W-1:0]   cur_slice_ff;
   logic                          sw_ff;
   logic                          att_ff;
   fps_pkg::err_type              err_ff;
   logic                          rd_ok_ff;
   logic                          rsp_valid_ff;
   fps_pkg::result_type           rsp_data_ff;

   fps_pkg::cmd_type              cmd;
   fps_pkg::entry_type            entries [TASKS];
   logic                          afters [TASKS];
   fps_pkg::entry_type            head;
   logic                          empty;
   logic                          full;
   logic                          wr_en;
   logic [ROW_W-1:0]              rd_raw;
   fps_pkg::row_type              rd_row;
   fps_pkg::row_type              wr_row;
   logic [fps_pkg::LVL_W-1:0]     exp_level;

   assign head  = entries[0];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(TASKS));

   // ready queue
   for (genvar i = 0; i < TASKS; i++) begin : g_cell
      fps_pkg::entry_type prev_entry;
      fps_pkg::entry_type next_entry;
      logic               prev_after;
      if (i == 0) begin : g_first
         assign prev_entry = entries[i];
         assign prev_after = 1'b1;
      end else begin : g_mid
         assign prev_entry = entries[i-1];
         assign prev_after = afters[i-1];
      end
      if (i == TASKS - 1) begin : g_last
         assign next_entry = entries[i];
      end else begin : g_next
         assign next_entry = entries[i+1];
      end
      fps_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (count_ff > CNT_W'(i)),
         .prev_after (prev_after),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entries[i]),
         .after      (afters[i])
      );
   end

   // dispatch table
   assign wr_row = '{sleep_level:   item_ff.row_sleep_level,
                     expired_level: item_ff.row_expired_level,
                     quantum:       item_ff.row_quantum};
   assign wr_en  = (state_ff == ST_DECODE) &&
                   (kind_ff == fps_pkg::KIND_LOAD) &&
                   (int'(item_ff.level) < LEVELS);

   fps_ram #(
      .WIDTH (ROW_W),
      .DEPTH (LEVELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (LA_W'(item_ff.level)),
      .wr_data (wr_row),
      .rd_addr (LA_W'(cur_level_ff)),
      .rd_data (rd_raw)
   );

   // rows beyond the table read as zero
   assign rd_row    = rd_ok_ff ? fps_pkg::row_type'(rd_raw) : '0;
   assign exp_level = rd_row.expired_level;

   always_comb begin
      cmd.op    = fps_pkg::CELL_HOLD;
      cmd.entry = '{task_id: item_ff.task_id, level: item_ff.level};
      unique case (state_ff)
         ST_DECODE: begin
            if (kind_ff == fps_pkg::KIND_READY && !full) begin
               cmd.op = fps_pkg::CELL_INSERT;
            end
         end
         ST_REQUEUE: begin
            cmd.op    = fps_pkg::CELL_INSERT;
            cmd.entry = '{task_id: cur_task_ff, level: cur_level_ff};
         end
         ST_DEQUEUE: begin
            if (!empty) begin
               cmd.op = fps_pkg::CELL_POP;
            end
         end
         default: begin
            cmd.op = fps_pkg::CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ok_ff <= (int'(cur_level_ff) < LEVELS);
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_task_ff  <= '0;
         cur_level_ff <= '0;
         cur_slice_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  item_ff  <= fps_pkg::item_type'(req_tdata[$bits(fps_pkg::item_type)-1:0]);
                  kind_ff  <= req_tuser;
                  sw_ff    <= 1'b0;
                  att_ff   <= 1'b0;
                  err_ff   <= fps_pkg::ERR_NONE;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               unique case (fps_pkg::kind_type'(kind_ff))
                  fps_pkg::KIND_READY: begin
                     if (full) begin
                        err_ff <= fps_pkg::ERR_FULL;
                     end else begin
                        count_ff <= count_ff + CNT_W'(1);
                     end
                     state_ff <= ST_DONE;
                  end
                  fps_pkg::KIND_RESCHED: begin
                     if (item_ff.defer_active) begin
                        att_ff   <= 1'b1;
                        state_ff <= ST_DONE;
                     end else begin
                        unique case (fps_pkg::status_type'(item_ff.current_status))
                           fps_pkg::STATUS_RUN:   state_ff <= ST_EXP_WAIT;
                           fps_pkg::STATUS_SLEEP: state_ff <= ST_SLP_WAIT;
                           default:               state_ff <= ST_DEQUEUE;
                        endcase
                     end
                  end
                  default: begin
                     state_ff <= ST_DONE;
                  end
               endcase
            end
            ST_EXP_WAIT: begin
               cur_level_ff <= exp_level;
               if (empty || exp_level > head.level) begin
                  state_ff <= ST_QNT_RD;
               end else if (full) begin
                  err_ff   <= fps_pkg::ERR_FULL;
                  state_ff <= ST_QNT_RD;
               end else begin
                  state_ff <= ST_REQUEUE;
               end
            end
            ST_SLP_WAIT: begin
               cur_level_ff <= rd_row.sleep_level;
               state_ff     <= ST_DEQUEUE;
            end
            ST_REQUEUE: begin
               count_ff <= count_ff + CNT_W'(1);
               state_ff <= ST_DEQUEUE;
            end
            ST_DEQUEUE: begin
               if (empty) begin
                  err_ff   <= fps_pkg::ERR_EMPTY;
                  state_ff <= ST_DONE;
               end else begin
                  sw_ff        <= (head.task_id != cur_task_ff);
                  cur_task_ff  <= head.task_id;
                  cur_level_ff <= head.level;
                  count_ff     <= count_ff - CNT_W'(1);
                  state_ff     <= ST_QNT_RD;
               end
            end
            ST_QNT_RD: begin
               state_ff <= ST_QNT_WAIT;
            end
            ST_QNT_WAIT: begin
               cur_slice_ff <= rd_row.quantum;
               state_ff     <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff                 <= 1'b1;
                  rsp_data_ff.running_task     <= cur_task_ff;
                  rsp_data_ff.running_level    <= cur_level_ff;
                  rsp_data_ff.slice_ticks      <= cur_slice_ff;
                  rsp_data_ff.switched         <= sw_ff;
                  rsp_data_ff.attempt_deferred <= att_ff;
                  rsp_data_ff.error            <= err_ff;
                  state_ff                     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TASKS))
      else $error("queue count beyond capacity");

   a_insert_room : assert property (@(posedge clock) disable iff (reset)
      cmd.op == fps_pkg::CELL_INSERT |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert without count update");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      cmd.op == fps_pkg::CELL_POP |-> !empty)
      else $error("pop from empty queue");

   a_defer_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.attempt_deferred |->
         !rsp_data_ff.switched && rsp_data_ff.error == fps_pkg::ERR_NONE)
      else $error("deferred beat carries switch or error");

   a_empty_no_switch : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.error == fps_pkg::ERR_EMPTY |-> !rsp_data_ff.switched)
      else $error("switch reported on empty dequeue");

endmodule
